// ----- rtl/lfps_pkg.sv -----
// Package for the LED flash pattern sequencer: request and result types,
// command and mode codes, and the configuration register set.
// No dependencies.
package lfps_pkg;

    localparam int unsigned TICK_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ON     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OFF    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LONG   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SHORT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SERIES = 3'd5;

    localparam logic [MODE_W-1:0] MODE_CODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_SINGLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_SERIES = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_ON     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE  = 3'd4;

    localparam logic [TICK_W-1:0] RESET_LONG  = 8'd4;
    localparam logic [TICK_W-1:0] RESET_SHORT = 8'd2;
    localparam logic [TICK_W-1:0] RESET_ON    = 8'd6;
    localparam logic [TICK_W-1:0] RESET_OFF   = 8'd12;
    localparam logic [TICK_W-1:0] RESET_PAUSE = 8'd35;

    typedef enum logic [3:0] {
        MODE_OFF    = 4'b0001,
        MODE_SINGLE = 4'b0010,
        MODE_SERIES = 4'b0100,
        MODE_ON     = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TICK_W-1:0] flash_count;
    } cmd_t;

    typedef struct packed {
        logic              led_lit;
        logic [MODE_W-1:0] mode_now;
    } rsp_t;

    typedef struct packed {
        logic [TICK_W-1:0] long_flash_ticks;
        logic [TICK_W-1:0] short_flash_ticks;
        logic [TICK_W-1:0] series_on_ticks;
        logic [TICK_W-1:0] series_off_ticks;
        logic [TICK_W-1:0] series_pause_ticks;
    } cfg_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        case (m)
            MODE_OFF:    code = MODE_CODE_OFF;
            MODE_SINGLE: code = MODE_CODE_SINGLE;
            MODE_SERIES: code = MODE_CODE_SERIES;
            MODE_ON:     code = MODE_CODE_ON;
            default:     code = MODE_CODE_OFF;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/lfps_cfg_regs.sv -----
// Configuration register file of the LED flash pattern sequencer.
// Depends on lfps_pkg.
module lfps_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [lfps_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [lfps_pkg::TICK_W-1:0]    wr_data,
    output lfps_pkg::cfg_t                 cfg
);
    import lfps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_LONG:  cfg_next.long_flash_ticks   = wr_data;
                REG_SHORT: cfg_next.short_flash_ticks  = wr_data;
                REG_ON:    cfg_next.series_on_ticks    = wr_data;
                REG_OFF:   cfg_next.series_off_ticks   = wr_data;
                REG_PAUSE: cfg_next.series_pause_ticks = wr_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_flash_ticks   <= RESET_LONG;
            cfg_reg.short_flash_ticks  <= RESET_SHORT;
            cfg_reg.series_on_ticks    <= RESET_ON;
            cfg_reg.series_off_ticks   <= RESET_OFF;
            cfg_reg.series_pause_ticks <= RESET_PAUSE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/lfps_core.sv -----
// Mode and counter state of the LED flash pattern sequencer, updated once per
// accepted request, with the result computed from the updated state.
// Depends on lfps_pkg.
module lfps_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  lfps_pkg::cmd_t cmd,
    input  lfps_pkg::cfg_t cfg,
    output lfps_pkg::rsp_t rsp_next
);
    import lfps_pkg::*;

    mode_t             mode_reg,   mode_next;
    logic              level_reg,  level_next;
    logic [TICK_W-1:0] ticks_reg,  ticks_next;
    logic [TICK_W-1:0] index_reg,  index_next;
    logic [TICK_W-1:0] length_reg, length_next;
    logic [TICK_W-1:0] ticks_dec;

    assign ticks_dec = ticks_reg - 1'b1;

    always_comb
    begin
        mode_next   = mode_reg;
        level_next  = level_reg;
        ticks_next  = ticks_reg;
        index_next  = index_reg;
        length_next = length_reg;
        case (cmd.kind)
            KIND_TICK:
            begin
                if (mode_reg == MODE_SINGLE)
                begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == '0)
                    begin
                        mode_next  = MODE_OFF;
                        level_next = 1'b0;
                    end
                end
                else if (mode_reg == MODE_SERIES)
                begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == '0)
                    begin
                        if (level_reg)
                        begin
                            if (index_reg == length_reg)
                            begin
                                ticks_next = cfg.series_pause_ticks;
                                index_next = '0;
                            end
                            else
                            begin
                                ticks_next = cfg.series_off_ticks;
                            end
                            level_next = 1'b0;
                        end
                        else
                        begin
                            index_next = index_reg + 1'b1;
                            ticks_next = cfg.series_on_ticks;
                            level_next = 1'b1;
                        end
                    end
                end
            end
            KIND_ON:
            begin
                mode_next  = MODE_ON;
                level_next = 1'b1;
            end
            KIND_OFF:
            begin
                mode_next  = MODE_OFF;
                level_next = 1'b0;
            end
            KIND_LONG:
            begin
                mode_next  = MODE_SINGLE;
                ticks_next = cfg.long_flash_ticks;
                level_next = 1'b1;
            end
            KIND_SHORT:
            begin
                mode_next  = MODE_SINGLE;
                ticks_next = cfg.short_flash_ticks;
                level_next = 1'b1;
            end
            KIND_SERIES:
            begin
                mode_next   = MODE_SERIES;
                length_next = cmd.flash_count;
                index_next  = TICK_W'(1);
                ticks_next  = cfg.series_on_ticks;
                level_next  = 1'b1;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OFF;
            level_reg  <= 1'b0;
            ticks_reg  <= '0;
            index_reg  <= '0;
            length_reg <= '0;
        end
        else if (en)
        begin
            mode_reg   <= mode_next;
            level_reg  <= level_next;
            ticks_reg  <= ticks_next;
            index_reg  <= index_next;
            length_reg <= length_next;
        end
    end

    assign rsp_next.led_lit  = level_next;
    assign rsp_next.mode_now = mode_code(mode_next);

endmodule

// ----- rtl/led_flash_pattern_sequencer.sv -----
// Top level of the LED flash pattern sequencer: request and result handshakes,
// configuration port and result register.
// Depends on lfps_pkg, lfps_cfg_regs and lfps_core.

// Every request (a 20 ms tick or a command) yields exactly one result holding
// the LED level and mode after that request. A request's result appears in the
// result register in the cycle after the request is taken, so one request per
// cycle is sustained while the result side is ready; the mode and counter
// registers are updated once per accepted request. The request side stalls only while
// a result waits and the result side is not ready. Configuration writes are
// always accepted; indexes beyond the last register are ignored.
module led_flash_pattern_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  lfps_pkg::cmd_t                 cmd,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output lfps_pkg::rsp_t                 rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfps_pkg::TICK_W-1:0]    cfg_data
);
    import lfps_pkg::*;

    cfg_t cfg;
    rsp_t rsp_next;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic cmd_accept;

    assign cfg_ready  = 1'b1;
    assign cmd_ready  = !rsp_valid_reg || rsp_ready;
    assign cmd_accept = cmd_valid && cmd_ready;

    lfps_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lfps_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (cmd_accept),
        .cmd      (cmd),
        .cfg      (cfg),
        .rsp_next (rsp_next)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd_accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n) cmd_valid && cmd_ready |=> rsp_valid
    ) else $error("accepted request did not produce a result");

    a_on_is_lit: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mode_now == MODE_CODE_ON |-> rsp.led_lit
    ) else $error("mode on reported with the LED dark");

    a_off_is_dark: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mode_now == MODE_CODE_OFF |-> !rsp.led_lit
    ) else $error("mode off reported with the LED lit");

endmodule

// ----- dv/led_flash_pattern_sequencer_test.sv -----
// Self-checking testbench for led_flash_pattern_sequencer: a queue-fed request
// driver, a result monitor checked against an internal LED sequencer model.
// Depends on lfps_pkg and the led_flash_pattern_sequencer RTL.
module led_flash_pattern_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lfps_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 150;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    cmd_t                 cmd = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]    cfg_data = '0;

    cmd_t        pending_cmds[$];
    rsp_t        led_reports_due[$];
    bit          cmd_taken = 1'b0;
    bit          idle_off = 1'b0;
    bit          rsp_hold_req = 1'b0;
    int unsigned cmd_gap = 0;
    int unsigned rsp_gap = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;

    logic [TICK_W-1:0] long_m = RESET_LONG;
    logic [TICK_W-1:0] short_m = RESET_SHORT;
    logic [TICK_W-1:0] on_m = RESET_ON;
    logic [TICK_W-1:0] off_m = RESET_OFF;
    logic [TICK_W-1:0] pause_m = RESET_PAUSE;
    logic [MODE_W-1:0] mode_m = MODE_CODE_OFF;
    logic              lit_m = 1'b0;
    logic [TICK_W-1:0] ticks_m = '0;
    logic [TICK_W-1:0] index_m = '0;
    logic [TICK_W-1:0] length_m = '0;

    led_flash_pattern_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic rsp_t predict_led(input cmd_t c);
        rsp_t r;
        case (c.kind)
            KIND_TICK:
            begin
                if (mode_m == MODE_CODE_SINGLE)
                begin
                    ticks_m = ticks_m - 8'd1;
                    if (ticks_m == 8'd0)
                    begin
                        mode_m = MODE_CODE_OFF;
                        lit_m = 1'b0;
                    end
                end
                else if (mode_m == MODE_CODE_SERIES)
                begin
                    ticks_m = ticks_m - 8'd1;
                    if (ticks_m == 8'd0)
                    begin
                        if (lit_m)
                        begin
                            if (index_m == length_m)
                            begin
                                ticks_m = pause_m;
                                index_m = 8'd0;
                            end
                            else
                            begin
                                ticks_m = off_m;
                            end
                            lit_m = 1'b0;
                        end
                        else
                        begin
                            index_m = index_m + 8'd1;
                            ticks_m = on_m;
                            lit_m = 1'b1;
                        end
                    end
                end
            end
            KIND_ON:
            begin
                mode_m = MODE_CODE_ON;
                lit_m = 1'b1;
            end
            KIND_OFF:
            begin
                mode_m = MODE_CODE_OFF;
                lit_m = 1'b0;
            end
            KIND_LONG:
            begin
                mode_m = MODE_CODE_SINGLE;
                ticks_m = long_m;
                lit_m = 1'b1;
            end
            KIND_SHORT:
            begin
                mode_m = MODE_CODE_SINGLE;
                ticks_m = short_m;
                lit_m = 1'b1;
            end
            KIND_SERIES:
            begin
                mode_m = MODE_CODE_SERIES;
                length_m = c.flash_count;
                index_m = 8'd1;
                ticks_m = on_m;
                lit_m = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.led_lit = lit_m;
        r.mode_now = mode_m;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (cmd_valid && cmd_ready)
            begin
                led_reports_due.push_back(predict_led(cmd));
                cmd_taken = 1'b1;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (led_reports_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: led_lit=%0b mode_now=%0d",
                                 rsp.led_lit, rsp.mode_now);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    rsp_t want;
                    want = led_reports_due.pop_front();
                    if (rsp.led_lit !== want.led_lit || rsp.mode_now !== want.mode_now)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected led_lit=%0b mode_now=%0d,",
                                     want.led_lit, want.mode_now,
                                     " got led_lit=%0b mode_now=%0d",
                                     rsp.led_lit, rsp.mode_now);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_taken)
            begin
            end
            else if (!idle_off && cmd_gap > 0)
            begin
                cmd_gap = cmd_gap - 1;
                cmd_valid = 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd = pending_cmds.pop_front();
                cmd_valid = 1'b1;
                cmd_gap = idle_off ? 0 : pick_gap();
            end
            else
            begin
                cmd_valid = 1'b0;
            end
            cmd_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rsp_ready = 1'b0;
                if (hold_left == 0)
                    rsp_hold_req = 1'b0;
            end
            else if (rsp_hold_req)
            begin
                hold_left = HOLD_CYCLES;
                rsp_ready = 1'b0;
            end
            else if (idle_off)
            begin
                rsp_ready = 1'b1;
            end
            else if (rsp_gap > 0)
            begin
                rsp_gap = rsp_gap - 1;
                rsp_ready = 1'b0;
            end
            else
            begin
                rsp_ready = 1'b1;
                rsp_gap = pick_gap();
            end
        end
    end

    task automatic push_cmd(input logic [KIND_W-1:0] kind, input logic [TICK_W-1:0] count);
        cmd_t c;
        c.kind = kind;
        c.flash_count = count;
        pending_cmds.push_back(c);
    endtask

    task automatic push_ticks(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            push_cmd(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_random(input int unsigned n);
        int unsigned r;
        int unsigned i;
        i = 0;
        while (i < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                int unsigned run;
                run = $urandom_range(5, 30);
                push_cmd(KIND_SERIES, 8'($urandom_range(1, 3)));
                push_ticks(run);
                i = i + run + 1;
            end
            else
            begin
                if (r < 60)
                    push_cmd(KIND_TICK, 8'($urandom_range(0, 255)));
                else if (r < 66)
                    push_cmd(KIND_ON, 8'($urandom_range(0, 255)));
                else if (r < 72)
                    push_cmd(KIND_OFF, 8'($urandom_range(0, 255)));
                else if (r < 79)
                    push_cmd(KIND_LONG, 8'($urandom_range(0, 255)));
                else if (r < 86)
                    push_cmd(KIND_SHORT, 8'($urandom_range(0, 255)));
                else if (r < 96)
                    push_cmd(KIND_SERIES, ($urandom_range(0, 9) < 7) ?
                             8'($urandom_range(1, 3)) : 8'($urandom_range(0, 255)));
                else
                    push_cmd(3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)));
                i = i + 1;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || led_reports_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_LONG:  long_m = data;
            REG_SHORT: short_m = data;
            REG_ON:    on_m = data;
            REG_OFF:   off_m = data;
            REG_PAUSE: pause_m = data;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [TICK_W-1:0] l, input logic [TICK_W-1:0] s,
                             input logic [TICK_W-1:0] on, input logic [TICK_W-1:0] off,
                             input logic [TICK_W-1:0] p);
        write_reg(REG_LONG, l);
        write_reg(REG_SHORT, s);
        write_reg(REG_ON, on);
        write_reg(REG_OFF, off);
        write_reg(REG_PAUSE, p);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: every command, unused kinds, and counters kept across on and off.
        push_cmd(KIND_TICK, 8'h00);
        push_cmd(KIND_OFF, 8'hFF);
        push_cmd(KIND_ON, 8'h00);
        push_cmd(KIND_TICK, 8'hAA);
        push_cmd(KIND_LONG, 8'h55);
        push_ticks(4);
        push_cmd(KIND_SHORT, 8'hFF);
        push_cmd(KIND_TICK, 8'h00);
        push_cmd(KIND_ON, 8'h0F);
        push_cmd(KIND_TICK, 8'hF0);
        push_cmd(KIND_SHORT, 8'h00);
        push_cmd(KIND_OFF, 8'h00);
        push_cmd(KIND_TICK, 8'hFF);
        push_cmd(3'd6, 8'hFF);
        push_cmd(3'd7, 8'h00);
        push_cmd(KIND_SERIES, 8'hFF);
        push_ticks(7);
        push_cmd(KIND_SERIES, 8'h00);
        push_cmd(3'd7, 8'hFF);
        wait_drained();

        // Lowest settings, plus writes to indexes past the last register.
        write_all(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        write_reg(3'd5, 8'hFF);
        write_reg(3'd6, 8'h00);
        write_reg(3'd7, 8'hA5);
        push_cmd(KIND_SERIES, 8'd2);
        push_ticks(8);
        queue_random(30);
        wait_drained();

        write_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_random(15);
        wait_drained();

        // The result side holds off while requests keep coming.
        write_all(8'd2, 8'd1, 8'd2, 8'd3, 8'd4);
        rsp_hold_req = 1'b1;
        queue_random(30);
        wait_drained();

        idle_off = 1'b1;
        write_all(8'd3, 8'd2, 8'd1, 8'd2, 8'd3);
        queue_random(15);
        wait_drained();
        idle_off = 1'b0;

        repeat (3)
        begin
            write_all(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                      8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                      8'($urandom_range(1, 8)));
            queue_random(5);
            wait_drained();
            queue_random(5);
            wait_drained();
        end

        // A register of zero wraps on the first tick, so the LED stays lit.
        write_all(8'd0, 8'd0, 8'd0, 8'd1, 8'd1);
        push_cmd(KIND_LONG, 8'h3C);
        push_ticks(3);
        push_cmd(KIND_SHORT, 8'h00);
        push_ticks(2);
        push_cmd(KIND_SERIES, 8'd1);
        push_ticks(2);
        push_cmd(KIND_OFF, 8'h00);
        wait_drained();

        // A flash count of zero runs 256 flashes before the pause.
        write_all(8'd7, 8'd5, 8'd1, 8'd1, 8'd2);
        push_cmd(KIND_SERIES, 8'd0);
        push_ticks(516);
        wait_drained();

        repeat (5) @(posedge clk);
        if (mismatches == 0 && led_reports_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
